// ===== hdl/dsac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsac_pkg
// Shared types and constants of the drain sensor and actuator controller.
// ----------------------------------------------------------------------------
package dsac_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned SPAN_W   = 16;
    localparam int unsigned DIST_W   = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned FLOW_W   = 2;

    localparam logic [TIME_W-1:0] METAL_HOLD_MS = 32'd800;

    localparam logic [DUTY_W-1:0] CONVEYOR_DUTY = 8'd145;
    localparam logic [DUTY_W-1:0] WIPER_DUTY    = 8'd40;
    localparam logic [DUTY_W-1:0] SERVO_METAL   = 8'd20;
    localparam logic [DUTY_W-1:0] SERVO_IDLE    = 8'd90;
    localparam logic [DUTY_W-1:0] DUTY_OFF      = 8'd0;

    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 10'd500;
    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 10'd650;
    localparam logic [LEVEL_W-1:0] RAIN_RST       = 10'd500;
    localparam logic [LEVEL_W-1:0] DETECT_RST     = 10'd20;
    localparam logic [SPAN_W-1:0]  CONVEYOR_RST   = 16'd5000;
    localparam logic [SPAN_W-1:0]  WIPER_ON_RST   = 16'd300;
    localparam logic [SPAN_W-1:0]  WIPER_OFF_RST  = 16'd2000;
    localparam logic [SPAN_W-1:0]  BLOCKAGE_RST   = 16'd15000;

    typedef enum logic [FLOW_W-1:0] {
        FLOW_NORMAL  = 2'd0,
        FLOW_PARTIAL = 2'd1,
        FLOW_SEVERE  = 2'd2
    } flow_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LEVEL  = 3'd0,
        CFG_HIGH_LEVEL = 3'd1,
        CFG_RAIN       = 3'd2,
        CFG_DETECT     = 3'd3,
        CFG_CONVEYOR   = 3'd4,
        CFG_WIPER_ON   = 3'd5,
        CFG_WIPER_OFF  = 3'd6,
        CFG_BLOCKAGE   = 3'd7
    } cfg_idx_t;

    // wrapping elapsed-time test
    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] start,
                                     input logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] diff;
        diff = now - start;
        return diff >= span;
    endfunction

endpackage

// ===== hdl/drain_sensor_actuator_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drain_sensor_actuator_controller
// Conveyor one-shot, wiper cycle, metal hold and blockage detection driven
// by time-stamped sensor samples.
// ----------------------------------------------------------------------------
// One sample set is taken per clock while in_stall is low and gives one
// result: the sample is held in an input register, then the control state
// and the result register are updated by four parallel 32-bit elapsed-time
// compares. A stalled result holds the input register, so at most two
// samples are in flight. Configuration writes take effect on the next cycle
// and must be made while no sample is in flight.
module drain_sensor_actuator_controller
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic [9:0]  low_level_sample,
    input  logic [9:0]  high_level_sample,
    input  logic [9:0]  rain_sample,
    input  logic        metal_sense,
    input  logic signed [10:0] distance_cm,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  conveyor_pwm,
    output logic [7:0]  wiper_pwm,
    output logic [7:0]  servo_angle,
    output logic [1:0]  flow_status
);

    // configuration
    logic [9:0]  low_thr_reg;
    logic [9:0]  high_thr_reg;
    logic [9:0]  rain_thr_reg;
    logic [9:0]  detect_reg;
    logic [15:0] conveyor_ms_reg;
    logic [15:0] wiper_on_ms_reg;
    logic [15:0] wiper_off_ms_reg;
    logic [15:0] blockage_ms_reg;

    // input stage
    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic [9:0]  s1_low_reg;
    logic [9:0]  s1_high_reg;
    logic [9:0]  s1_rain_reg;
    logic        s1_metal_reg;
    logic [10:0] s1_dist_reg;

    // control state
    logic        object_seen_reg;
    logic        conveyor_on_reg;
    logic [31:0] conveyor_start_reg;
    logic        wiper_on_reg;
    logic [31:0] wiper_start_reg;
    logic        metal_held_reg;
    logic [31:0] metal_start_reg;
    logic        flow_timing_reg;
    logic [31:0] flow_start_reg;
    logic        severe_reg;
    logic        partial_reg;

    logic        object_seen_next;
    logic        conveyor_on_next;
    logic [31:0] conveyor_start_next;
    logic        wiper_on_next;
    logic [31:0] wiper_start_next;
    logic        metal_held_next;
    logic [31:0] metal_start_next;
    logic        flow_timing_next;
    logic [31:0] flow_start_next;
    logic        severe_next;
    logic        partial_next;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  conveyor_pwm_reg;
    logic [7:0]  wiper_pwm_reg;
    logic [7:0]  servo_angle_reg;
    logic [1:0]  flow_status_reg;
    logic [1:0]  flow_status_next;

    logic        out_free;
    logic        s1_move;
    logic        in_take;

    logic        detected;
    logic        water_low;
    logic        water_high;
    logic        wet;
    logic        conveyor_start_now;
    logic        conveyor_on_mid;
    logic [31:0] conveyor_start_mid;
    logic [31:0] wiper_span;
    logic        wiper_done;
    logic [31:0] flow_start_mid;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // sample decode
    assign detected   = !s1_dist_reg[10] && (s1_dist_reg[9:0] != 10'd0)
                        && (s1_dist_reg[9:0] <= detect_reg);
    assign water_low  = s1_low_reg > low_thr_reg;
    assign water_high = s1_high_reg > high_thr_reg;
    assign wet        = s1_rain_reg > rain_thr_reg;

    always_comb
    begin
        // conveyor one-shot
        conveyor_start_now  = detected && !object_seen_reg && !conveyor_on_reg;
        conveyor_on_mid     = conveyor_on_reg || conveyor_start_now;
        conveyor_start_mid  = conveyor_start_now ? s1_now_reg : conveyor_start_reg;
        conveyor_start_next = conveyor_start_mid;
        object_seen_next    = detected && (object_seen_reg || conveyor_start_now);
        conveyor_on_next    = conveyor_on_mid
                              && !dsac_pkg::elapsed(s1_now_reg, conveyor_start_mid,
                                                    {16'd0, conveyor_ms_reg});

        // wiper cycle
        wiper_span       = wiper_on_reg ? {16'd0, wiper_on_ms_reg}
                                        : {16'd0, wiper_off_ms_reg};
        wiper_done       = dsac_pkg::elapsed(s1_now_reg, wiper_start_reg, wiper_span);
        wiper_on_next    = wiper_done ? !wiper_on_reg : wiper_on_reg;
        wiper_start_next = wiper_done ? s1_now_reg : wiper_start_reg;

        // metal hold
        metal_start_next = !s1_metal_reg ? s1_now_reg : metal_start_reg;
        metal_held_next  = (metal_held_reg || !s1_metal_reg)
                           && !dsac_pkg::elapsed(s1_now_reg, metal_start_next,
                                                 dsac_pkg::METAL_HOLD_MS);

        // blockage detection
        flow_start_mid = flow_timing_reg ? flow_start_reg : s1_now_reg;
        if (wet && water_low)
        begin
            flow_timing_next = 1'b1;
            flow_start_next  = flow_start_mid;
            if (dsac_pkg::elapsed(s1_now_reg, flow_start_mid, {16'd0, blockage_ms_reg}))
            begin
                severe_next  = water_high;
                partial_next = !water_high;
            end
            else
            begin
                severe_next  = severe_reg;
                partial_next = partial_reg;
            end
        end
        else
        begin
            flow_timing_next = 1'b0;
            flow_start_next  = 32'd0;
            severe_next      = 1'b0;
            partial_next     = 1'b0;
        end

        priority if (severe_next)
            flow_status_next = dsac_pkg::FLOW_SEVERE;
        else if (partial_next)
            flow_status_next = dsac_pkg::FLOW_PARTIAL;
        else
            flow_status_next = dsac_pkg::FLOW_NORMAL;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg      <= dsac_pkg::LOW_LEVEL_RST;
            high_thr_reg     <= dsac_pkg::HIGH_LEVEL_RST;
            rain_thr_reg     <= dsac_pkg::RAIN_RST;
            detect_reg       <= dsac_pkg::DETECT_RST;
            conveyor_ms_reg  <= dsac_pkg::CONVEYOR_RST;
            wiper_on_ms_reg  <= dsac_pkg::WIPER_ON_RST;
            wiper_off_ms_reg <= dsac_pkg::WIPER_OFF_RST;
            blockage_ms_reg  <= dsac_pkg::BLOCKAGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (dsac_pkg::cfg_idx_t'(cfg_index))
                dsac_pkg::CFG_LOW_LEVEL:  low_thr_reg      <= cfg_data[9:0];
                dsac_pkg::CFG_HIGH_LEVEL: high_thr_reg     <= cfg_data[9:0];
                dsac_pkg::CFG_RAIN:       rain_thr_reg     <= cfg_data[9:0];
                dsac_pkg::CFG_DETECT:     detect_reg       <= cfg_data[9:0];
                dsac_pkg::CFG_CONVEYOR:   conveyor_ms_reg  <= cfg_data;
                dsac_pkg::CFG_WIPER_ON:   wiper_on_ms_reg  <= cfg_data;
                dsac_pkg::CFG_WIPER_OFF:  wiper_off_ms_reg <= cfg_data;
                dsac_pkg::CFG_BLOCKAGE:   blockage_ms_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_now_reg   <= now_ms;
            s1_low_reg   <= low_level_sample;
            s1_high_reg  <= high_level_sample;
            s1_rain_reg  <= rain_sample;
            s1_metal_reg <= metal_sense;
            s1_dist_reg  <= distance_cm;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_seen_reg    <= 1'b0;
            conveyor_on_reg    <= 1'b0;
            conveyor_start_reg <= 32'd0;
            wiper_on_reg       <= 1'b1;
            wiper_start_reg    <= 32'd0;
            metal_held_reg     <= 1'b0;
            metal_start_reg    <= 32'd0;
            flow_timing_reg    <= 1'b0;
            flow_start_reg     <= 32'd0;
            severe_reg         <= 1'b0;
            partial_reg        <= 1'b0;
        end
        else if (s1_move)
        begin
            object_seen_reg    <= object_seen_next;
            conveyor_on_reg    <= conveyor_on_next;
            conveyor_start_reg <= conveyor_start_next;
            wiper_on_reg       <= wiper_on_next;
            wiper_start_reg    <= wiper_start_next;
            metal_held_reg     <= metal_held_next;
            metal_start_reg    <= metal_start_next;
            flow_timing_reg    <= flow_timing_next;
            flow_start_reg     <= flow_start_next;
            severe_reg         <= severe_next;
            partial_reg        <= partial_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            conveyor_pwm_reg <= conveyor_on_next ? dsac_pkg::CONVEYOR_DUTY
                                                 : dsac_pkg::DUTY_OFF;
            wiper_pwm_reg    <= wiper_on_next ? dsac_pkg::WIPER_DUTY : dsac_pkg::DUTY_OFF;
            servo_angle_reg  <= metal_held_next ? dsac_pkg::SERVO_METAL
                                                : dsac_pkg::SERVO_IDLE;
            flow_status_reg  <= flow_status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign conveyor_pwm = conveyor_pwm_reg;
    assign wiper_pwm    = wiper_pwm_reg;
    assign servo_angle  = servo_angle_reg;
    assign flow_status  = flow_status_reg;

endmodule

// ===== hdl/dsac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsac_checker
// Port-level checks of the drain sensor and actuator controller results.
// ----------------------------------------------------------------------------
module dsac_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] conveyor_pwm,
    input  logic [7:0] wiper_pwm,
    input  logic [7:0] servo_angle,
    input  logic [1:0] flow_status
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(conveyor_pwm)
            && $stable(wiper_pwm) && $stable(servo_angle) && $stable(flow_status))
        else $error("stalled result changed");

    a_conveyor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (conveyor_pwm == dsac_pkg::CONVEYOR_DUTY)
            || (conveyor_pwm == dsac_pkg::DUTY_OFF))
        else $error("bad conveyor duty");

    a_wiper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wiper_pwm == dsac_pkg::WIPER_DUTY)
            || (wiper_pwm == dsac_pkg::DUTY_OFF))
        else $error("bad wiper duty");

    a_servo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (servo_angle == dsac_pkg::SERVO_METAL)
            || (servo_angle == dsac_pkg::SERVO_IDLE))
        else $error("bad servo angle");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flow_status == dsac_pkg::FLOW_NORMAL)
            || (flow_status == dsac_pkg::FLOW_PARTIAL)
            || (flow_status == dsac_pkg::FLOW_SEVERE))
        else $error("bad flow status");

endmodule

bind drain_sensor_actuator_controller dsac_checker u_dsac_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .conveyor_pwm (conveyor_pwm),
    .wiper_pwm    (wiper_pwm),
    .servo_angle  (servo_angle),
    .flow_status  (flow_status)
);

// ===== tb/sv/tb_drain_sensor_actuator_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drain_sensor_actuator_controller
// Self-checking bench for the drain controller. A short table of sensor
// samples, some with typed-in results, is followed by randomized sample
// streams under several register settings. Every result transfer is checked
// field by field against a typed-in result or an in-bench four-control model.
// ----------------------------------------------------------------------------
module tb_drain_sensor_actuator_controller;

    localparam int N_REGS = 2 ** dsac_pkg::CFG_IDX_W;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 48;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0]        now;
        logic [9:0]         low;
        logic [9:0]         high;
        logic [9:0]         rain;
        logic               metal;
        logic signed [10:0] distance;
    } sample_t;

    typedef struct packed {
        logic [7:0]             conveyor;
        logic [7:0]             wiper;
        logic [7:0]             servo;
        dsac_pkg::flow_status_t flow;
    } result_t;

    typedef struct packed {
        sample_t s;
        logic    typed;
        result_t r;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] now_ms;
    logic [9:0]  low_level_sample;
    logic [9:0]  high_level_sample;
    logic [9:0]  rain_sample;
    logic        metal_sense;
    logic signed [10:0] distance_cm;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  conveyor_pwm;
    logic [7:0]  wiper_pwm;
    logic [7:0]  servo_angle;
    logic [1:0]  flow_status;

    // model registers
    logic [9:0]  thr_low;
    logic [9:0]  thr_high;
    logic [9:0]  thr_rain;
    logic [9:0]  thr_detect;
    logic [15:0] span_conveyor;
    logic [15:0] span_wipe_on;
    logic [15:0] span_wipe_off;
    logic [15:0] span_blockage;

    // model control state
    logic        obj_seen;
    logic        conv_on;
    logic [31:0] conv_t0;
    logic        wipe_on;
    logic [31:0] wipe_t0;
    logic        metal_on;
    logic [31:0] metal_t0;
    logic        flow_armed;
    logic [31:0] flow_t0;
    logic        severe;
    logic        partial;

    // stimulus shaping
    logic [31:0] clock_ms;
    bit          storm;
    bit          rising;
    bit          near;
    bit          steady;
    bit          hold_request;

    row_t        directed_rows[$];
    result_t     expected_results[$];
    int          mismatches;

    drain_sensor_actuator_controller uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .now_ms            (now_ms),
        .low_level_sample  (low_level_sample),
        .high_level_sample (high_level_sample),
        .rain_sample       (rain_sample),
        .metal_sense       (metal_sense),
        .distance_cm       (distance_cm),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .conveyor_pwm      (conveyor_pwm),
        .wiper_pwm         (wiper_pwm),
        .servo_angle       (servo_angle),
        .flow_status       (flow_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] ms_since(input logic [31:0] t, input logic [31:0] t0);
        return t - t0;
    endfunction

    task automatic reset_model();
        thr_low       = dsac_pkg::LOW_LEVEL_RST;
        thr_high      = dsac_pkg::HIGH_LEVEL_RST;
        thr_rain      = dsac_pkg::RAIN_RST;
        thr_detect    = dsac_pkg::DETECT_RST;
        span_conveyor = dsac_pkg::CONVEYOR_RST;
        span_wipe_on  = dsac_pkg::WIPER_ON_RST;
        span_wipe_off = dsac_pkg::WIPER_OFF_RST;
        span_blockage = dsac_pkg::BLOCKAGE_RST;
        obj_seen   = 1'b0;
        conv_on    = 1'b0;
        conv_t0    = '0;
        wipe_on    = 1'b1;
        wipe_t0    = '0;
        metal_on   = 1'b0;
        metal_t0   = '0;
        flow_armed = 1'b0;
        flow_t0    = '0;
        severe     = 1'b0;
        partial    = 1'b0;
    endtask

    task automatic store_register(input dsac_pkg::cfg_idx_t idx, input logic [15:0] val);
        case (idx)
            dsac_pkg::CFG_LOW_LEVEL:  thr_low = val[9:0];
            dsac_pkg::CFG_HIGH_LEVEL: thr_high = val[9:0];
            dsac_pkg::CFG_RAIN:       thr_rain = val[9:0];
            dsac_pkg::CFG_DETECT:     thr_detect = val[9:0];
            dsac_pkg::CFG_CONVEYOR:   span_conveyor = val;
            dsac_pkg::CFG_WIPER_ON:   span_wipe_on = val;
            dsac_pkg::CFG_WIPER_OFF:  span_wipe_off = val;
            dsac_pkg::CFG_BLOCKAGE:   span_blockage = val;
            default:                  ;
        endcase
    endtask

    task automatic advance_controls(input sample_t s, output result_t r);
        logic detected;
        logic water_low;
        logic water_high;
        logic wet;
        detected   = !s.distance[10] && (s.distance != 11'sd0)
                     && (s.distance[9:0] <= thr_detect);
        water_low  = s.low > thr_low;
        water_high = s.high > thr_high;
        wet        = s.rain > thr_rain;

        if (detected && !obj_seen && !conv_on)
        begin
            obj_seen = 1'b1;
            conv_on  = 1'b1;
            conv_t0  = s.now;
        end
        if (!detected)
            obj_seen = 1'b0;
        if (conv_on && ms_since(s.now, conv_t0) >= {16'd0, span_conveyor})
            conv_on = 1'b0;

        if (wipe_on)
        begin
            if (ms_since(s.now, wipe_t0) >= {16'd0, span_wipe_on})
            begin
                wipe_on = 1'b0;
                wipe_t0 = s.now;
            end
        end
        else if (ms_since(s.now, wipe_t0) >= {16'd0, span_wipe_off})
        begin
            wipe_on = 1'b1;
            wipe_t0 = s.now;
        end

        if (!s.metal)
        begin
            metal_on = 1'b1;
            metal_t0 = s.now;
        end
        if (metal_on && ms_since(s.now, metal_t0) >= dsac_pkg::METAL_HOLD_MS)
            metal_on = 1'b0;

        if (wet && water_low)
        begin
            if (!flow_armed)
            begin
                flow_armed = 1'b1;
                flow_t0    = s.now;
            end
            if (ms_since(s.now, flow_t0) >= {16'd0, span_blockage})
            begin
                severe  = water_high;
                partial = !water_high;
            end
        end
        else
        begin
            flow_armed = 1'b0;
            flow_t0    = '0;
            severe     = 1'b0;
            partial    = 1'b0;
        end

        r.conveyor = conv_on ? dsac_pkg::CONVEYOR_DUTY : dsac_pkg::DUTY_OFF;
        r.wiper    = wipe_on ? dsac_pkg::WIPER_DUTY : dsac_pkg::DUTY_OFF;
        r.servo    = metal_on ? dsac_pkg::SERVO_METAL : dsac_pkg::SERVO_IDLE;
        r.flow     = severe ? dsac_pkg::FLOW_SEVERE
                            : (partial ? dsac_pkg::FLOW_PARTIAL : dsac_pkg::FLOW_NORMAL);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_row(input logic [31:0] t, input int lo, input int hi, input int rn,
                           input logic mp, input int d, input logic typed,
                           input int conv, input int wip, input int servo,
                           input dsac_pkg::flow_status_t fl);
        row_t row;
        row.s.now      = t;
        row.s.low      = 10'(lo);
        row.s.high     = 10'(hi);
        row.s.rain     = 10'(rn);
        row.s.metal    = mp;
        row.s.distance = 11'(d);
        row.typed      = typed;
        row.r.conveyor = 8'(conv);
        row.r.wiper    = 8'(wip);
        row.r.servo    = 8'(servo);
        row.r.flow     = fl;
        directed_rows.push_back(row);
    endtask

    function automatic logic [9:0] level_pick(input logic [9:0] thr, input bit above);
        if (above && thr != 10'h3FF)
            return 10'($urandom_range(1023, thr + 1));
        else if (!above)
            return 10'($urandom_range(thr, 0));
        return 10'($urandom_range(1023, 0));
    endfunction

    task automatic draw_sample(input int unsigned step_max, output sample_t s);
        if ($urandom_range(99) < 8)
        begin
            s.now      = $urandom;
            s.low      = 10'($urandom);
            s.high     = 10'($urandom);
            s.rain     = 10'($urandom);
            s.metal    = 1'($urandom);
            s.distance = 11'($urandom);
        end
        else
        begin
            if ($urandom_range(99) < 5)
                clock_ms += $urandom_range(step_max * 8, 0);
            else
                clock_ms += $urandom_range(step_max, 0);
            if ($urandom_range(99) < 3)
                storm = !storm;
            if ($urandom_range(99) < 10)
                rising = !rising;
            if ($urandom_range(99) < 15)
                near = !near;
            s.now   = clock_ms;
            s.rain  = level_pick(thr_rain, storm);
            s.low   = level_pick(thr_low, storm || ($urandom_range(99) < 30));
            s.high  = level_pick(thr_high, rising);
            s.metal = $urandom_range(99) >= 10;
            if (near)
                s.distance = (thr_detect == 0) ? 11'sd1
                                               : 11'($urandom_range(thr_detect, 1));
            else if ($urandom_range(99) < 70)
                s.distance = (thr_detect == 10'h3FF) ? 11'sd0
                                                     : 11'($urandom_range(1023, thr_detect + 1));
            else if ($urandom_range(1) == 1)
                s.distance = 11'(0 - $urandom_range(1024, 1));
            else
                s.distance = 11'sd0;
        end
    endtask

    task automatic send_sample(input sample_t s, input logic typed, input result_t want);
        result_t modeled;
        while (!steady && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        now_ms            <= s.now;
        low_level_sample  <= s.low;
        high_level_sample <= s.high;
        rain_sample       <= s.rain;
        metal_sense       <= s.metal;
        distance_cm       <= s.distance;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        advance_controls(s, modeled);
        expected_results.push_back(typed ? want : modeled);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input int unsigned lv_lo, input int unsigned lv_hi,
                                     input int unsigned sp_lo, input int unsigned sp_hi);
        dsac_pkg::cfg_idx_t idx;
        logic [15:0]        val;
        for (int i = 0; i < N_REGS; i++)
        begin
            idx = dsac_pkg::cfg_idx_t'(i);
            case (idx)
                dsac_pkg::CFG_LOW_LEVEL, dsac_pkg::CFG_HIGH_LEVEL,
                dsac_pkg::CFG_RAIN, dsac_pkg::CFG_DETECT:
                    val = 16'($urandom_range(lv_hi, lv_lo));
                default:
                    val = 16'($urandom_range(sp_hi, sp_lo));
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            store_register(idx, val);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int unsigned step_max,
                             input int hold_at, input int pause_at,
                             input int steady_lo, input int steady_hi);
        sample_t s;
        result_t blank;
        blank = '0;
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= steady_lo) && (i < steady_hi);
            if (i == hold_at)
                hold_request = 1'b1;
            if (i == pause_at)
                drain_block();
            draw_sample(step_max, s);
            send_sample(s, 1'b0, blank);
        end
        steady = 1'b0;
    endtask

    // result side: random stall plus one long hold-off
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 27);
        end
    end

    // result transfer happens at the next rising edge
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf(
                    "unexpected result conveyor=%0d wiper=%0d servo=%0d flow=%0d",
                    conveyor_pwm, wiper_pwm, servo_angle, flow_status));
            else
            begin
                want = expected_results.pop_front();
                if (conveyor_pwm !== want.conveyor)
                    report_mismatch($sformatf("conveyor_pwm got %0d want %0d",
                                              conveyor_pwm, want.conveyor));
                if (wiper_pwm !== want.wiper)
                    report_mismatch($sformatf("wiper_pwm got %0d want %0d",
                                              wiper_pwm, want.wiper));
                if (servo_angle !== want.servo)
                    report_mismatch($sformatf("servo_angle got %0d want %0d",
                                              servo_angle, want.servo));
                if (flow_status !== want.flow)
                    report_mismatch($sformatf("flow_status got %0d want %0d",
                                              flow_status, want.flow));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        mismatches   = 0;
        storm        = 1'b0;
        rising       = 1'b0;
        near         = 1'b0;
        steady       = 1'b0;
        hold_request = 1'b0;
        clock_ms     = '0;
        reset_model();

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= dsac_pkg::CFG_LOW_LEVEL;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        now_ms            <= '0;
        low_level_sample  <= '0;
        high_level_sample <= '0;
        rain_sample       <= '0;
        metal_sense       <= 1'b1;
        distance_cm       <= '0;

        // now, low, high, rain, metal, distance, typed, conveyor, wiper, servo, flow
        add_row(32'd0,     0,    0,    0,    1, -1,    1, 0,   40, 90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd100,   0,    0,    0,    0, 10,    1, 145, 40, 20, dsac_pkg::FLOW_NORMAL);
        add_row(32'd300,   0,    0,    0,    1, 10,    1, 145, 0,  20, dsac_pkg::FLOW_NORMAL);
        add_row(32'd1100,  1023, 1023, 1023, 1, 1023,  1, 145, 0,  90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd16100, 1023, 1023, 1023, 1, 0,     1, 0,   40, 90, dsac_pkg::FLOW_SEVERE);
        add_row(32'd16200, 1023, 0,    1023, 1, 0,     1, 0,   40, 90, dsac_pkg::FLOW_PARTIAL);
        add_row(32'd16300, 1023, 1023, 0,    1, 0,     1, 0,   40, 90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd16400, 0,    0,    0,    1, 20,    1, 145, 0,  90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd16500, 0,    0,    0,    1, 21,    1, 145, 0,  90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd16600, 0,    0,    0,    1, -1024, 1, 145, 0,  90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd16700, 0,    0,    0,    0, 1,     1, 145, 0,  20, dsac_pkg::FLOW_NORMAL);
        // timestamp wrap, samples exactly at thresholds
        add_row(32'hFFFF_FFFF, 500, 650, 500, 1, -1,   1, 0,   40, 90, dsac_pkg::FLOW_NORMAL);
        // blockage window starting at time zero
        add_row(32'd0,     501,  651,  501,  1, -1,    1, 0,   40, 90, dsac_pkg::FLOW_NORMAL);
        add_row(32'd15000, 501,  651,  501,  1, -1,    1, 0,   0,  90, dsac_pkg::FLOW_SEVERE);
        add_row(32'd15001, 501,  650,  501,  0, 5,     0, 0,   0,  0,  dsac_pkg::FLOW_NORMAL);
        add_row(32'd15100, 1023, 0,    1023, 1, 5,     0, 0,   0,  0,  dsac_pkg::FLOW_NORMAL);
        add_row(32'd20000, 511,  512,  1022, 0, 1023,  0, 0,   0,  0,  dsac_pkg::FLOW_NORMAL);
        add_row(32'd20001, 682,  341,  682,  1, 682,   0, 0,   0,  0,  dsac_pkg::FLOW_NORMAL);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].r);

        drain_block();
        clock_ms = $urandom;
        run_phase(150, 800, -1, -1, -1, -1);

        drain_block();
        program_registers(300, 700, 0, 400);
        clock_ms = $urandom;
        run_phase(250, 120, 60, 120, 150, 250);

        // zero thresholds and zero periods
        drain_block();
        program_registers(0, 0, 0, 0);
        clock_ms = $urandom;
        run_phase(150, 5, -1, -1, -1, -1);

        // all ones, levels keep the low ten bits
        drain_block();
        program_registers(65535, 65535, 65535, 65535);
        clock_ms = $urandom;
        run_phase(150, 20000, -1, -1, -1, -1);

        drain_block();
        program_registers(0, 65535, 0, 65535);
        clock_ms = $urandom;
        run_phase(150, 16000, -1, -1, -1, -1);

        // run across the timestamp wrap
        drain_block();
        program_registers(0, 1023, 1, 3000);
        clock_ms = 32'hFFFF_0000 + $urandom_range(4095, 0);
        run_phase(300, 1000, -1, -1, -1, -1);

        drain_block();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsac_pkg.sv
hdl/drain_sensor_actuator_controller.sv
hdl/dsac_checker.sv
tb/sv/tb_drain_sensor_actuator_controller.sv
